### rtl/core/cda_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and calendar helpers for the calendar date adder.
// No dependencies; every other file imports this package.
package cda_pkg;

  localparam logic [1:0] ACT_DAYS   = 2'd0;
  localparam logic [1:0] ACT_MONTHS = 2'd1;
  localparam logic [1:0] ACT_YEARS  = 2'd2;

  localparam logic [1:0] DIV_NONE   = 2'd0;
  localparam logic [1:0] DIV_YEAR   = 2'd1;
  localparam logic [1:0] DIV_TOTAL  = 2'd2;
  localparam logic [1:0] DIV_RESULT = 2'd3;

  localparam logic [1:0]  DIV_STEPS    = 2'd2;
  localparam logic [8:0]  LEAP_CYCLE   = 9'd400;
  localparam logic [16:0] YEAR_LAST    = 17'd65535;

  // Reciprocals of 3 and 25 scaled by 2^16. They give exact quotients for
  // dividends below 32768 and below 4681 respectively.
  localparam logic [31:0] RECIP_THREE      = 32'd21846;
  localparam logic [31:0] RECIP_TWENTYFIVE = 32'd2622;

  typedef struct packed {
    logic       capture;
    logic [1:0] div_op;
    logic       clean;
    logic       doy_step;
    logic       year_step;
    logic       mon_step;
    logic       set_month;
    logic       set_ovf;
    logic       fix;
    logic       load_out;
  } cda_cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       amt_zero;
    logic       doy_more;
    logic       year_more;
    logic       mon_more;
    logic       ry_over;
    logic       ovf;
    logic       div_busy;
  } cda_status_t;

  // Leap test on the year taken modulo 400.
  function automatic logic is_leap(input logic [8:0] r);
    logic cent;
    cent = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
    return (r == 9'd0) || ((r[1:0] == 2'b00) && !cent);
  endfunction

  function automatic logic [4:0] month_days(input logic leap, input logic [3:0] m);
    logic [4:0] n;
    case (m) inside
      4'd2: n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic [8:0] year_days(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

endpackage

### rtl/core/calendar_date_adder.sv
`timescale 1ns / 1ps
// Top level of the calendar date adder: controller, datapath and checks.
// Depends on cda_pkg, cda_control and cda_datapath.
//
// Usage: an input word (start date, action, amount) is accepted when in_valid is
// high and in_stall is low. One result word (end date and overflow flag) is offered
// on out_valid and taken when out_stall is low.
// The block works on one word at a time. Every word first reduces the start year
// modulo 400 in a two-stage reciprocal divider, then picks the action. A zero
// amount of days or the unused action goes straight to the output word; adding years
// takes a modulo-400 pass on the result year, adding months a division by 12 and a
// second modulo-400 pass. Adding days walks up to 11 months for the day of year,
// then crosses one whole year per cycle (about 180 for the largest amount), then up
// to 12 months. The year walk takes most of the time for day additions.
// A finished word sits in the output register; the next input word can be accepted in the
// following cycle even while it waits, and its result is held back until the receiver
// takes the first.
// Synchronous reset clears the controller and the output valid flag.
module calendar_date_adder import cda_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] start_year,
  input  logic [3:0]  start_month,
  input  logic [4:0]  start_day,
  input  logic [1:0]  action,
  input  logic [15:0] amount,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] end_year,
  output logic [3:0]  end_month,
  output logic [4:0]  end_day,
  output logic        overflow
);

  cda_cmd_t    cmd;
  cda_status_t status;

  cda_control u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  cda_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .start_year  (start_year),
    .start_month (start_month),
    .start_day   (start_day),
    .action      (action),
    .amount      (amount),
    .end_year    (end_year),
    .end_month   (end_month),
    .end_day     (end_day),
    .overflow    (overflow)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted but block did not go busy");

  a_div_idle_when_ready: assert property (@(posedge clk) disable iff (rst)
    status.div_busy |-> in_stall)
    else $error("divider running while block accepts input");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (end_month >= 4'd1) && (end_month <= 4'd12))
    else $error("result month out of range");

endmodule

### rtl/core/cda_divider.sv
`timescale 1ns / 1ps
// Two-stage divider by 400 or by 12 using reciprocal multiplication.
// Depends on cda_pkg. Division by 400 takes dividends below 65536.
module cda_divider import cda_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        by_twelve,
  input  logic [16:0] dividend,
  output logic        busy,
  output logic [16:0] quotient,
  output logic [8:0]  remainder
);

  logic [1:0]  cnt;
  logic        twelve;
  logic [16:0] num;
  logic [31:0] prod;
  logic [16:0] back;
  logic [16:0] diff;

  assign busy = (cnt != 2'd0);
  assign prod = twelve ? ({17'd0, num[16:2]} * RECIP_THREE)
                       : ({20'd0, num[15:4]} * RECIP_TWENTYFIVE);
  assign back = twelve ? ({quotient[13:0], 3'd0} + {quotient[14:0], 2'd0})
                       : ({quotient[8:0], 8'd0} + {quotient[9:0], 7'd0} +
                          {quotient[12:0], 4'd0});
  assign diff = num - back;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (start) begin
      cnt <= DIV_STEPS;
    end else if (busy) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      twelve <= by_twelve;
      num    <= dividend;
    end else if (cnt == DIV_STEPS) begin
      quotient <= {1'b0, prod[31:16]};
    end else if (busy) begin
      remainder <= diff[8:0];
    end
  end

endmodule

### rtl/core/cda_datapath.sv
`timescale 1ns / 1ps
// Datapath of the calendar date adder: date registers, day-of-year walk and output word.
// Depends on cda_pkg and cda_divider.
module cda_datapath import cda_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cda_cmd_t    cmd,
  output cda_status_t status,
  input  logic [15:0] start_year,
  input  logic [3:0]  start_month,
  input  logic [4:0]  start_day,
  input  logic [1:0]  action,
  input  logic [15:0] amount,
  output logic [15:0] end_year,
  output logic [3:0]  end_month,
  output logic [4:0]  end_day,
  output logic        overflow
);

  logic [15:0] y;
  logic [3:0]  m;
  logic [4:0]  d;
  logic [1:0]  act;
  logic [15:0] amt;
  logic [16:0] ry;
  logic [3:0]  rm;
  logic [4:0]  rd;
  logic [8:0]  doy;
  logic [3:0]  idx;
  logic [8:0]  r400;
  logic        ovf;

  logic        dv_start;
  logic        dv_busy;
  logic [16:0] dv_dividend;
  logic [16:0] dv_quot;
  logic [8:0]  dv_rem;

  logic        leap_now;
  logic        leap_div;
  logic [4:0]  lim_clean;
  logic [4:0]  d_clean;
  logic [4:0]  lim_fix;
  logic [4:0]  dim_idx;
  logic [4:0]  dim_rm;
  logic [8:0]  year_left;
  logic        year_more;
  logic        mon_more;
  logic [16:0] ry_inc;
  logic [16:0] total;
  logic [16:0] ry_months;

  assign leap_now  = is_leap(r400);
  assign leap_div  = is_leap(dv_rem);
  assign lim_clean = month_days(leap_div, m);
  assign d_clean   = (d == 5'd0) ? 5'd1 : ((d > lim_clean) ? lim_clean : d);
  assign lim_fix   = month_days(leap_div, rm);
  assign dim_idx   = month_days(leap_now, idx);
  assign dim_rm    = month_days(leap_now, rm);
  assign year_left = year_days(leap_now) - doy;
  assign year_more = ({7'd0, year_left} < amt);
  assign mon_more  = (rm < 4'd12) && (doy > {4'd0, dim_rm});
  assign ry_inc    = ry + 17'd1;
  assign total     = {13'd0, m - 4'd1} + {1'b0, amt};
  assign ry_months = {1'b0, y} + dv_quot;

  assign dv_start = (cmd.div_op != DIV_NONE);

  always_comb begin
    case (cmd.div_op)
      DIV_YEAR:   dv_dividend = {1'b0, start_year};
      DIV_TOTAL:  dv_dividend = total;
      DIV_RESULT: dv_dividend = ry;
      default:    dv_dividend = 17'd0;
    endcase
  end

  cda_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (dv_start),
    .by_twelve (cmd.div_op == DIV_TOTAL),
    .dividend  (dv_dividend),
    .busy      (dv_busy),
    .quotient  (dv_quot),
    .remainder (dv_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      y   <= start_year;
      m   <= (start_month == 4'd0) ? 4'd1 : ((start_month > 4'd12) ? 4'd12 : start_month);
      d   <= start_day;
      act <= action;
      amt <= amount;
      ovf <= 1'b0;
    end
    if (cmd.clean) begin
      r400 <= dv_rem;
      d    <= d_clean;
      rd   <= d_clean;
      rm   <= m;
      doy  <= {4'd0, d_clean};
      idx  <= 4'd1;
      ry   <= (act == ACT_YEARS) ? ({1'b0, y} + {1'b0, amt}) : {1'b0, y};
    end
    if (cmd.doy_step) begin
      doy <= doy + {4'd0, dim_idx};
      idx <= idx + 4'd1;
    end
    if (cmd.year_step) begin
      if (year_more) begin
        amt  <= amt - {7'd0, year_left} - 16'd1;
        doy  <= 9'd1;
        ry   <= ry_inc;
        r400 <= (r400 == LEAP_CYCLE - 9'd1) ? 9'd0 : r400 + 9'd1;
        ovf  <= ry_inc[16];
      end else begin
        doy <= doy + amt[8:0];
        rm  <= 4'd1;
      end
    end
    if (cmd.mon_step) begin
      if (mon_more) begin
        doy <= doy - {4'd0, dim_rm};
        rm  <= rm + 4'd1;
      end else begin
        rd <= doy[4:0];
      end
    end
    if (cmd.set_month) begin
      ry <= ry_months;
      rm <= dv_rem[3:0] + 4'd1;
    end
    if (cmd.set_ovf) begin
      ovf <= 1'b1;
    end
    if (cmd.fix) begin
      if (rd > lim_fix) begin
        rd <= lim_fix;
      end
    end
    if (cmd.load_out) begin
      end_year  <= ovf ? y : ry[15:0];
      end_month <= ovf ? m : rm;
      end_day   <= ovf ? d : rd;
      overflow  <= ovf;
    end
  end

  always_comb begin
    status.act       = act;
    status.amt_zero  = (amt == 16'd0);
    status.doy_more  = (idx < m);
    status.year_more = year_more;
    status.mon_more  = mon_more;
    status.ry_over   = (ry > YEAR_LAST);
    status.ovf       = ovf;
    status.div_busy  = dv_busy;
  end

endmodule

### rtl/core/cda_control.sv
`timescale 1ns / 1ps
// Controller of the calendar date adder: sequences cleanup, walks and the output word.
// Depends on cda_pkg.
module cda_control import cda_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  cda_status_t status,
  output cda_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MODY   = 4'd1;
  localparam logic [3:0] S_BRANCH = 4'd2;
  localparam logic [3:0] S_DOY    = 4'd3;
  localparam logic [3:0] S_YEAR   = 4'd4;
  localparam logic [3:0] S_MON    = 4'd5;
  localparam logic [3:0] S_DIVM   = 4'd6;
  localparam logic [3:0] S_CHKM   = 4'd7;
  localparam logic [3:0] S_MODR   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.div_op  = DIV_YEAR;
          state_next  = S_MODY;
        end
      end
      S_MODY: begin
        if (!status.div_busy) begin
          cmd.clean  = 1'b1;
          state_next = S_BRANCH;
        end
      end
      S_BRANCH: begin
        case (status.act)
          ACT_DAYS: begin
            state_next = status.amt_zero ? S_DONE : S_DOY;
          end
          ACT_MONTHS: begin
            cmd.div_op = DIV_TOTAL;
            state_next = S_DIVM;
          end
          ACT_YEARS: begin
            if (status.ry_over) begin
              cmd.set_ovf = 1'b1;
              state_next  = S_DONE;
            end else begin
              cmd.div_op = DIV_RESULT;
              state_next = S_MODR;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_DOY: begin
        if (status.doy_more) begin
          cmd.doy_step = 1'b1;
        end else begin
          state_next = S_YEAR;
        end
      end
      S_YEAR: begin
        if (status.ovf) begin
          state_next = S_DONE;
        end else begin
          cmd.year_step = 1'b1;
          if (!status.year_more) begin
            state_next = S_MON;
          end
        end
      end
      S_MON: begin
        cmd.mon_step = 1'b1;
        if (!status.mon_more) begin
          state_next = S_DONE;
        end
      end
      S_DIVM: begin
        if (!status.div_busy) begin
          cmd.set_month = 1'b1;
          state_next    = S_CHKM;
        end
      end
      S_CHKM: begin
        if (status.ry_over) begin
          cmd.set_ovf = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.div_op = DIV_RESULT;
          state_next = S_MODR;
        end
      end
      S_MODR: begin
        if (!status.div_busy) begin
          cmd.fix    = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid_next = cmd.load_out | (out_valid & out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### sim/calendar_date_adder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for calendar_date_adder: directed and random date words with
// random input gaps and output stalls, each result checked against a behavioral predictor.
// Depends on cda_pkg and the calendar_date_adder RTL.
module calendar_date_adder_tb;
  import cda_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int unsigned YEAR_TOP = 65535;
  localparam int RANDOM_WORDS = 1400;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 300;
  localparam int QUIET_SEND_LO = 300;
  localparam int QUIET_SEND_HI = 500;
  localparam int QUIET_TAKE_LO = 700;
  localparam int QUIET_TAKE_HI = 900;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [1:0]  act;
    logic [15:0] amount;
  } date_word_t;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        ovf;
  } date_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] start_year = '0;
  logic [3:0]  start_month = '0;
  logic [4:0]  start_day = '0;
  logic [1:0]  action = '0;
  logic [15:0] amount = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] end_year;
  logic [3:0]  end_month;
  logic [4:0]  end_day;
  logic        overflow;

  date_word_t   words_pending[$];
  date_result_t dates_due[$];
  int           word_total;
  int           sent_cnt = 0;
  int           got_cnt = 0;
  int           misses = 0;
  int           send_gap = 0;
  int           stall_left = 0;
  int           cycle_count = 0;

  calendar_date_adder dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .start_year (start_year),
    .start_month(start_month),
    .start_day  (start_day),
    .action     (action),
    .amount     (amount),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .end_year   (end_year),
    .end_month  (end_month),
    .end_day    (end_day),
    .overflow   (overflow)
  );

  function automatic bit leap_of(int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int unsigned month_len(int unsigned y, int unsigned m);
    case (m)
      2: return leap_of(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic int unsigned year_len(int unsigned y);
    return leap_of(y) ? 366 : 365;
  endfunction

  // Out-of-range months and days are pulled into range first; an overflow
  // returns that cleaned starting date.
  function automatic date_result_t shift_date(date_word_t w);
    int unsigned y, m, d, n, ry, rm, rd, doy, lim, total, i;
    bit ovf;
    date_result_t res;
    y = w.year;
    m = w.month;
    d = w.day;
    n = w.amount;
    ovf = 1'b0;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    lim = month_len(y, m);
    if (d < 1) d = 1;
    if (d > lim) d = lim;
    ry = y;
    rm = m;
    rd = d;
    case (w.act)
      ACT_DAYS: begin
        if (n != 0) begin
          doy = d;
          for (i = 1; i < m; i++) doy += month_len(ry, i);
          while (!ovf && year_len(ry) - doy < n) begin
            n -= year_len(ry) - doy + 1;
            doy = 1;
            ry++;
            if (ry > YEAR_TOP) ovf = 1'b1;
          end
          if (!ovf) begin
            doy += n;
            rm = 1;
            while (rm < 12 && doy > month_len(ry, rm)) begin
              doy -= month_len(ry, rm);
              rm++;
            end
            rd = doy;
          end
        end
      end
      ACT_MONTHS: begin
        total = (m - 1) + n;
        ry = y + total / 12;
        rm = total % 12 + 1;
        if (ry > YEAR_TOP) begin
          ovf = 1'b1;
        end else begin
          lim = month_len(ry, rm);
          if (rd > lim) rd = lim;
        end
      end
      ACT_YEARS: begin
        ry = y + n;
        if (ry > YEAR_TOP) begin
          ovf = 1'b1;
        end else if (rm == 2 && rd == 29 && !leap_of(ry)) begin
          rd = 28;
        end
      end
      default: begin
      end
    endcase
    if (ovf) begin
      ry = y;
      rm = m;
      rd = d;
    end
    res.year = ry[15:0];
    res.month = rm[3:0];
    res.day = rd[4:0];
    res.ovf = ovf;
    return res;
  endfunction

  function automatic int pick_pause();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(1, 3);
    if (r < 90) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  task automatic add_word(int y, int m, int d, logic [1:0] a, int n);
    date_word_t w;
    w.year = y[15:0];
    w.month = m[3:0];
    w.day = d[4:0];
    w.act = a;
    w.amount = n[15:0];
    words_pending.push_back(w);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[calendar_date_adder] ERROR");
    $finish;
  end

  always @(posedge clk) begin : feed_words
    date_word_t w;
    logic nxt_valid;
    nxt_valid = in_valid;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        w.year = start_year;
        w.month = start_month;
        w.day = start_day;
        w.act = action;
        w.amount = amount;
        dates_due.push_back(shift_date(w));
        sent_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          nxt_valid = 1'b0;
        end else if (words_pending.size() > 0) begin
          w = words_pending.pop_front();
          start_year <= w.year;
          start_month <= w.month;
          start_day <= w.day;
          action <= w.act;
          amount <= w.amount;
          nxt_valid = 1'b1;
          if ((sent_cnt >= QUIET_SEND_LO && sent_cnt < QUIET_SEND_HI) || $urandom_range(1))
            send_gap = 0;
          else
            send_gap = pick_pause();
        end else begin
          nxt_valid = 1'b0;
        end
      end
    end
    in_valid <= nxt_valid;
  end

  always @(posedge clk) begin : take_results
    date_result_t want;
    logic nxt_stall;
    nxt_stall = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got_cnt++;
        if (dates_due.size() == 0) begin
          misses++;
          if (misses <= 10)
            $display("unexpected result %0d-%0d-%0d ovf %0b", end_year, end_month, end_day,
                     overflow);
        end else begin
          want = dates_due.pop_front();
          if (end_year !== want.year || end_month !== want.month || end_day !== want.day ||
              overflow !== want.ovf) begin
            misses++;
            if (misses <= 10)
              $display("mismatch: expected %0d-%0d-%0d ovf %0b, got %0d-%0d-%0d ovf %0b",
                       want.year, want.month, want.day, want.ovf,
                       end_year, end_month, end_day, overflow);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        nxt_stall = 1'b1;
      end else if (!(got_cnt >= QUIET_TAKE_LO && got_cnt < QUIET_TAKE_HI) &&
                   $urandom_range(5) == 0) begin
        stall_left = pick_pause() - 1;
        nxt_stall = 1'b1;
      end
    end
    out_stall <= nxt_stall;
  end

  initial begin : stimulus
    int r, y, m, d, n;
    logic [1:0] a;

    add_word(2024, 2, 29, ACT_DAYS, 1);
    add_word(2023, 12, 31, ACT_DAYS, 1);
    add_word(1900, 2, 28, ACT_DAYS, 1);
    add_word(2000, 2, 28, ACT_DAYS, 1);
    add_word(2024, 1, 31, ACT_MONTHS, 1);
    add_word(2023, 1, 31, ACT_MONTHS, 1);
    add_word(2024, 2, 29, ACT_YEARS, 1);
    add_word(2024, 2, 29, ACT_YEARS, 4);
    add_word(65535, 12, 31, ACT_DAYS, 1);
    add_word(65535, 12, 31, ACT_DAYS, 0);
    add_word(65535, 1, 15, ACT_MONTHS, 12);
    add_word(65535, 6, 15, ACT_YEARS, 1);
    add_word(1, 1, 1, ACT_DAYS, 65535);
    add_word(1, 1, 1, ACT_MONTHS, 65535);
    add_word(1, 1, 1, ACT_YEARS, 65535);
    add_word(2001, 0, 0, ACT_DAYS, 10);
    add_word(2001, 15, 31, ACT_MONTHS, 1);
    add_word(2001, 4, 31, ACT_YEARS, 0);
    add_word(0, 2, 29, ACT_DAYS, 1);
    add_word(2010, 13, 0, ACT_SPARE, 500);
    add_word(65535, 6, 15, ACT_YEARS, 0);
    add_word(2100, 2, 29, ACT_DAYS, 365);
    add_word(65400, 3, 1, ACT_DAYS, 65535);
    add_word(2000, 12, 31, ACT_DAYS, 65535);
    add_word(399, 12, 31, ACT_MONTHS, 0);

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      r = $urandom_range(19);
      if (r < 8) y = $urandom_range(65535);
      else if (r < 13) y = $urandom_range(1, 2500);
      else if (r < 16) y = $urandom_range(64500, 65535);
      else y = 100 * $urandom_range(0, 655) + $urandom_range(0, 4);
      m = ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom_range(15);
      r = $urandom_range(9);
      if (r < 6) d = $urandom_range(1, 28);
      else if (r < 9) d = $urandom_range(29, 31);
      else d = $urandom_range(31);
      r = $urandom_range(9);
      if (r < 3) a = ACT_DAYS;
      else if (r < 6) a = ACT_MONTHS;
      else if (r < 9) a = ACT_YEARS;
      else a = ACT_SPARE;
      r = $urandom_range(9);
      if (r < 4) n = $urandom_range(65535);
      else if (r < 7) n = $urandom_range(400);
      else n = $urandom_range(5000);
      add_word(y, m, d, a, n);
    end
    word_total = words_pending.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    wait (sent_cnt == word_total);
    wait (got_cnt >= word_total);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (misses == 0 && dates_due.size() == 0) begin
      $display("[calendar_date_adder] OK");
    end else begin
      $display("[calendar_date_adder] ERROR");
    end
    $finish;
  end

endmodule
